@@ design/cqs_pkg.sv @@
// ----------------------------------------------------------------------------
// cqs_pkg
// Shared types and constants for the circular queue with search.
// ----------------------------------------------------------------------------
package cqs_pkg;

    localparam int CODE_W   = 32;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;
    localparam int RESULT_W = CODE_W + 1 + STATUS_W + COUNT_W + 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_ENQUEUE = 2'd1,
        OP_DEQUEUE = 2'd2,
        OP_SEARCH  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                is_empty;
        logic [COUNT_W-1:0]  entry_count;
        t_status             status;
        logic                found;
        logic [CODE_W-1:0]   out_code;
    } t_result;

endpackage

@@ design/cqs_ram.sv @@
// ----------------------------------------------------------------------------
// cqs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/circular_queue_with_search_top.sv @@
// ----------------------------------------------------------------------------
// circular_queue_with_search_top
// Ring-buffer FIFO of 32-bit codes with clear, enqueue, dequeue and search.
// ----------------------------------------------------------------------------
// Input beats carry the opcode in tuser and the code in tdata. Every input
// beat yields exactly one output beat with the dequeued code, the search
// flag, a status, the entry count after the step and an empty flag.
// The ring holds at most SLOTS-1 codes in a single RAM with registered read.
// Clear and enqueue finish in the accept cycle and their result goes to the
// output register. Dequeue adds the S_DEQ state for the RAM read. Search reads
// one entry a cycle from head to tail in the S_SRCH state and stops on the
// first match. Status-only answers on an empty or full queue also finish in
// the accept cycle.
// A new beat is taken in the cycle after the previous one finishes, even
// while its result still waits in the output register; if a second result
// is ready before the first is taken, input stalls until the output frees.
// Reset empties the queue (head, tail and count to zero) and drops any
// pending result; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module circular_queue_with_search_top #(
    parameter int SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // item_code
    input  logic [cqs_pkg::CODE_W-1:0]        i_s_axis_tdata,
    // opcode
    input  logic [cqs_pkg::OPCODE_W-1:0]      i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_code, found, status, entry_count, is_empty
    output logic [cqs_pkg::RESULT_W-1:0]      o_m_axis_tdata
);

    import cqs_pkg::*;

    localparam int IW = $clog2(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SRCH,
        S_HOLD
    } t_state;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] i_idx);
        logic [IW-1:0] v;
        if (i_idx == IW'(SLOTS - 1)) begin
            v = '0;
        end else begin
            v = i_idx + 1'b1;
        end
        return v;
    endfunction

    t_state             r_state, n_state;
    logic [IW-1:0]      r_head, n_head;
    logic [IW-1:0]      r_tail, n_tail;
    logic [IW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_rd, n_rd;
    logic [CODE_W-1:0]  r_key;
    t_result            r_res;
    t_result            r_m_res;
    logic               r_m_valid;

    t_result            w_res;
    logic               w_done;
    logic               w_accept;
    logic               w_out_free;
    logic               w_we;
    logic [IW-1:0]      w_raddr;
    logic [CODE_W-1:0]  w_rdata;
    logic [IW+3:0]      w_count_ext;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_m_valid || i_m_axis_tready;
    assign w_raddr         = (r_state == S_SRCH) ? r_rd : r_head;

    cqs_ram #(
        .WIDTH(CODE_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_rd     = r_rd;
        w_done   = 1'b0;
        w_we     = 1'b0;
        w_res.out_code = '0;
        w_res.found    = 1'b0;
        w_res.status   = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_opcode'(i_s_axis_tuser))
                        OP_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            w_done  = 1'b1;
                        end
                        OP_ENQUEUE: begin
                            w_done = 1'b1;
                            if (f_next(r_tail) == r_head) begin
                                w_res.status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_tail  = f_next(r_tail);
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_DEQUEUE: begin
                            if (r_head == r_tail) begin
                                w_res.status = ST_EMPTY;
                                w_done       = 1'b1;
                            end else begin
                                n_state = S_DEQ;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_head == r_tail) begin
                                w_res.status = ST_EMPTY;
                                w_done       = 1'b1;
                            end else begin
                                n_rd    = f_next(r_head);
                                n_state = S_SRCH;
                            end
                        end
                    endcase
                end
            end
            S_DEQ: begin
                w_res.out_code = w_rdata;
                n_head         = f_next(r_head);
                n_count        = r_count - 1'b1;
                w_done         = 1'b1;
            end
            S_SRCH: begin
                if (w_rdata == r_key) begin
                    w_res.found = 1'b1;
                    w_done      = 1'b1;
                end else if (r_rd == r_tail) begin
                    w_done = 1'b1;
                end else begin
                    n_rd = f_next(r_rd);
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_done) begin
            n_state = w_out_free ? S_IDLE : S_HOLD;
        end
        w_count_ext       = {4'b0000, n_count};
        w_res.entry_count = w_count_ext[COUNT_W-1:0];
        w_res.is_empty    = (n_head == n_tail);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_rd      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_rd    <= n_rd;
            if (w_done && !w_out_free) begin
                r_res <= w_res;
            end
            if ((w_done || r_state == S_HOLD) && w_out_free) begin
                r_m_valid <= 1'b1;
                r_m_res   <= w_done ? w_res : r_res;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_s_axis_tdata;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_res;

endmodule

@@ design/cqs_checker.sv @@
// ----------------------------------------------------------------------------
// cqs_checker
// Port-level checks on the circular queue with search, bound to the top.
// ----------------------------------------------------------------------------
module cqs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [cqs_pkg::RESULT_W-1:0]      o_m_axis_tdata
);

    import cqs_pkg::*;

    t_result w_res;
    assign w_res = o_m_axis_tdata;

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // a waiting result beat is held
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // empty queue reports zero entries
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_res.is_empty |-> w_res.entry_count == '0)
        else $error("empty flag with nonzero count");

    // a failed step returns no code and no match
    a_fail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_res.status != ST_OK)
            |-> !w_res.found && (w_res.out_code == '0))
        else $error("code or match on failed step");

endmodule

bind circular_queue_with_search_top cqs_checker u_cqs_checker (.*);

@@ tb/sv/tb_circular_queue_with_search_top.sv @@
// ----------------------------------------------------------------------------
// tb_circular_queue_with_search_top
// Self-checking bench for the ring-buffer queue with clear, enqueue, dequeue
// and search. A tracker class keeps its own copy of the ring, predicts each
// result from every accepted input beat and checks the output beats in
// order. Stimulus is a short directed run through the corner cases, then
// random fill and drain phases with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_circular_queue_with_search_top;

    import cqs_pkg::*;

    localparam int SLOTS        = 16;
    localparam int IW           = $clog2(SLOTS);
    localparam int RANDOM_BEATS = 1400;
    localparam int SETTLE       = 40;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // item_code
    logic [CODE_W-1:0]   i_s_axis_tdata  = '0;
    // opcode
    logic [OPCODE_W-1:0] i_s_axis_tuser  = OP_CLEAR;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // out_code, found, status, entry_count, is_empty
    logic [RESULT_W-1:0] o_m_axis_tdata;

    circular_queue_with_search_top #(.SLOTS(SLOTS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    class queue_tracker;
        logic [CODE_W-1:0] ring [SLOTS];
        int unsigned       head_idx;
        int unsigned       tail_idx;
        int unsigned       fill;
        t_result           awaited_results[$];
        int                errors;
        int                checked;
        int                full_rejects;
        int                empty_answers;
        int                search_hits;
        int                wraps;

        function new();
            head_idx = 0;
            tail_idx = 0;
            fill     = 0;
            errors   = 0;
            checked  = 0;
            full_rejects  = 0;
            empty_answers = 0;
            search_hits   = 0;
            wraps         = 0;
        endfunction

        // code of a random stored entry, for searches that should hit
        function logic [CODE_W-1:0] stored_code();
            return ring[IW'((head_idx + $urandom_range(0, fill - 1)) % SLOTS)];
        endfunction

        function void note_beat(t_opcode op, logic [CODE_W-1:0] code);
            t_result     res;
            int unsigned idx;
            res        = '0;
            res.status = ST_OK;
            case (op)
                OP_CLEAR: begin
                    head_idx = 0;
                    tail_idx = 0;
                    fill     = 0;
                end
                OP_ENQUEUE: begin
                    if ((tail_idx + 1) % SLOTS == head_idx) begin
                        res.status = ST_FULL;
                        full_rejects++;
                    end else begin
                        ring[IW'(tail_idx)] = code;
                        tail_idx = (tail_idx + 1) % SLOTS;
                        if (tail_idx == 0) wraps++;
                        fill++;
                    end
                end
                OP_DEQUEUE: begin
                    if (head_idx == tail_idx) begin
                        res.status = ST_EMPTY;
                        empty_answers++;
                    end else begin
                        res.out_code = ring[IW'(head_idx)];
                        head_idx = (head_idx + 1) % SLOTS;
                        fill--;
                    end
                end
                default: begin
                    if (head_idx == tail_idx) begin
                        res.status = ST_EMPTY;
                        empty_answers++;
                    end else begin
                        idx = head_idx;
                        while (idx != tail_idx && !res.found) begin
                            if (ring[IW'(idx)] == code) res.found = 1'b1;
                            idx = (idx + 1) % SLOTS;
                        end
                        if (res.found) search_hits++;
                    end
                end
            endcase
            res.entry_count = COUNT_W'(fill);
            res.is_empty    = (head_idx == tail_idx);
            awaited_results.push_back(res);
        endfunction

        task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
            errors++;
        endtask

        task check_beat(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited", 64'(got), '0);
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (got.out_code !== want.out_code)
                report_mismatch("out_code", 64'(got.out_code), 64'(want.out_code));
            if (got.found !== want.found)
                report_mismatch("found", 64'(got.found), 64'(want.found));
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
            if (got.is_empty !== want.is_empty)
                report_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
        endtask
    endclass

    queue_tracker tracker = new();

    int burst_left = 0;
    int rx_mode    = 0;
    int rx_cycle   = 0;
    int stall_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: checks each accepted beat, then picks the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_beat(t_result'(o_m_axis_tdata));
        rx_cycle++;
        if (rx_cycle % 100 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2: i_m_axis_tready <= (rx_cycle % 5 == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_m_axis_tready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 25);
                    i_m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    task automatic send_beat(input t_opcode op, input logic [CODE_W-1:0] code);
        int gap;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= code;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_beat(op, code);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited_results.size() != 0);
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'hffff_ffff;
            4: return CODE_W'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_opcode pick_op(bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) return OP_CLEAR;
        if (roll < 27) return OP_SEARCH;
        if (filling) return (roll < 87) ? OP_ENQUEUE : OP_DEQUEUE;
        return (roll < 87) ? OP_DEQUEUE : OP_ENQUEUE;
    endfunction

    initial begin
        t_opcode           op;
        logic [CODE_W-1:0] code;
        bit                filling;
        int                phase_left;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue answers, extremes, fill to full and one beyond
        send_beat(OP_DEQUEUE, $urandom);
        send_beat(OP_SEARCH, 32'h0);
        send_beat(OP_ENQUEUE, 32'h8000_0000);
        send_beat(OP_ENQUEUE, 32'h7fff_ffff);
        send_beat(OP_ENQUEUE, 32'h0);
        send_beat(OP_ENQUEUE, 32'hffff_ffff);
        for (int k = 4; k < SLOTS - 1; k++) send_beat(OP_ENQUEUE, $urandom);
        send_beat(OP_ENQUEUE, 32'h1234_5678);
        send_beat(OP_SEARCH, 32'h7fff_ffff);
        send_beat(OP_SEARCH, 32'h5a5a_5a5a);
        send_beat(OP_DEQUEUE, 32'h0);
        send_beat(OP_CLEAR, $urandom);
        send_beat(OP_SEARCH, 32'h8000_0000);
        wait_drained();

        filling    = 1'b1;
        phase_left = 0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            op   = pick_op(filling);
            code = random_code();
            if (op == OP_SEARCH && tracker.fill > 0 && $urandom_range(0, 1) == 1)
                code = tracker.stored_code();
            send_beat(op, code);
            if (n == RANDOM_BEATS / 2 || $urandom_range(0, 199) == 0) wait_drained();
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("checked %0d results: %0d full rejects, %0d empty answers, %0d search hits",
                 tracker.checked, tracker.full_rejects, tracker.empty_answers,
                 tracker.search_hits);
        $display("ring wrapped %0d times, %0d mismatches", tracker.wraps, tracker.errors);
        if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
            $display("tb_circular_queue_with_search_top passed");
        end else begin
            $display("tb_circular_queue_with_search_top failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_circular_queue_with_search_top failed");
        $finish;
    end

endmodule
